@@ design/plb_pkg.sv @@
package plb_pkg;

    localparam int CH_BITS   = 8;
    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 3;
    localparam int MODE_W    = 2;
    localparam int GAIN_W    = 11;
    localparam int GAIN_FRAC = 8;
    localparam int PROD_W    = CH_BITS + GAIN_W;
    localparam int WIDE_W    = 2 * CH_BITS;
    localparam int ADDR_W    = 4;
    localparam int APB_W     = 32;

    localparam logic [CH_BITS-1:0] CH_MAX = '1;

    // Division by the full-scale value is a multiply by a rounded-up reciprocal.
    // The shift leaves enough guard bits that the quotient is exact for every
    // numerator below 2^(2*CH_BITS).
    localparam int DIV_SHIFT = 3 * CH_BITS + 1;
    localparam int RECIP_W   = 2 * CH_BITS + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) / ((64'd1 << CH_BITS) - 64'd1)) + 64'd1);

    localparam logic [MODE_W-1:0] MODE_MIX  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MULT = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_GAIN  = 2'd2;

    localparam logic [MODE_W-1:0]  RST_MODE  = MODE_MIX;
    localparam logic [COUNT_W-1:0] RST_COUNT = 3'd4;
    localparam logic [GAIN_W-1:0]  RST_GAIN  = 11'd256;

    typedef logic [CH_BITS-1:0] t_chan;
    typedef logic [WIDE_W-1:0]  t_wide;

    typedef enum logic [4:0] {
        OP_PASS  = 5'b00001,
        OP_MIX   = 5'b00010,
        OP_ADD   = 5'b00100,
        OP_MULT  = 5'b01000,
        OP_ALPHA = 5'b10000
    } t_slot_op;

    function automatic t_chan div_max(input t_wide x);
        logic [WIDE_W+RECIP_W-1:0] prod;
        prod = (WIDE_W+RECIP_W)'(x) * (WIDE_W+RECIP_W)'(RECIP);
        return prod[DIV_SHIFT +: CH_BITS];
    endfunction

endpackage

@@ design/pixel_layer_blend.sv @@
// Layer blender: one lower and one upper pixel enter per cycle and one blended
// pixel leaves per cycle while the output is not stalled, through a seven-stage pipeline
// whose stages each hold at most one level of multiplication. Backpressure is per stage, so
// a stalled output only stops the stages that are full behind it, and empty
// stages close up. Slot k of a pixel is bits [8k+7:8k]; the down pixel sits
// below the up pixel on the input bus. Of the channel_count slots in use the
// last one is alpha; the effective alpha is the upper alpha times mix_gain
// (Q3.8), saturated at 255. Registers: blend_mode at 0x0 (0 mix, 1 add,
// 2 multiply; 3 leaves the pixel untouched), channel_count at 0x4 (values
// above 5 act as 5, zero passes the pixel through), mix_gain at 0x8.
// Change registers only while no pixel is in flight.
module pixel_layer_blend (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [plb_pkg::ADDR_W-1:0]                   paddr,
    input  logic [plb_pkg::APB_W-1:0]                    pwdata,
    output logic [plb_pkg::APB_W-1:0]                    prdata,
    output logic                                         pready,
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // down_slot0..4, then up_slot0..4, 8 bits each
    input  logic [2*plb_pkg::NUM_SLOTS*plb_pkg::CH_BITS-1:0] i_s_axis_tdata,
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // out_slot0..4, 8 bits each
    output logic [plb_pkg::NUM_SLOTS*plb_pkg::CH_BITS-1:0]   o_m_axis_tdata
);
    import plb_pkg::*;

    // Configuration registers.
    logic [MODE_W-1:0]  r_mode;
    logic [COUNT_W-1:0] r_count;
    logic [GAIN_W-1:0]  r_gain;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_count <= RST_COUNT;
            r_gain  <= RST_GAIN;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:  r_mode  <= pwdata[MODE_W-1:0];
                REG_COUNT: r_count <= pwdata[COUNT_W-1:0];
                REG_GAIN:  r_gain  <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:  prdata = APB_W'(r_mode);
            REG_COUNT: prdata = APB_W'(r_count);
            REG_GAIN:  prdata = APB_W'(r_gain);
            default:   prdata = '0;
        endcase
    end

    // Stage enables: a stage may load when it is empty or moves on itself.
    logic en1, en2, en3, en4, en5, en6, en7;
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;

    assign en7 = !r7_v || i_m_axis_tready;
    assign en6 = !r6_v || en7;
    assign en5 = !r5_v || en6;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign o_s_axis_tready = en1;
    assign o_m_axis_tvalid = r7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_s_axis_tvalid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
            if (en6) r6_v <= r5_v;
            if (en7) r7_v <= r6_v;
        end
    end

    // Input decode: each slot gets its operation, and the alpha product starts.
    t_chan              in_d [NUM_SLOTS];
    t_chan              in_u [NUM_SLOTS];
    t_slot_op           in_kind [NUM_SLOTS];
    t_slot_op           color_op;
    logic [COUNT_W-1:0] n_eff;
    logic [SLOT_W-1:0]  last;
    logic               active;
    t_chan              alpha_u;
    logic [PROD_W-1:0]  n1_prod;

    always_comb begin
        n_eff  = (r_count > COUNT_W'(NUM_SLOTS)) ? COUNT_W'(NUM_SLOTS) : r_count;
        last   = SLOT_W'(n_eff - COUNT_W'(1));
        active = (n_eff != '0) &&
                 (r_mode == MODE_MIX || r_mode == MODE_ADD || r_mode == MODE_MULT);
        case (r_mode)
            MODE_MIX:  color_op = OP_MIX;
            MODE_ADD:  color_op = OP_ADD;
            MODE_MULT: color_op = OP_MULT;
            default:   color_op = OP_PASS;
        endcase
        alpha_u = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            in_d[i] = i_s_axis_tdata[i*CH_BITS +: CH_BITS];
            in_u[i] = i_s_axis_tdata[(NUM_SLOTS+i)*CH_BITS +: CH_BITS];
            if (!active) begin
                in_kind[i] = OP_PASS;
            end else if (SLOT_W'(i) < last) begin
                in_kind[i] = color_op;
            end else if (SLOT_W'(i) == last) begin
                in_kind[i] = OP_ALPHA;
            end else begin
                in_kind[i] = OP_PASS;
            end
            if (active && SLOT_W'(i) == last) begin
                alpha_u = in_u[i];
            end
        end
        n1_prod = PROD_W'(alpha_u) * PROD_W'(r_gain);
    end

    // Stage registers (payload, no reset).
    t_chan             r1_d [NUM_SLOTS];
    t_chan             r1_u [NUM_SLOTS];
    t_slot_op          r1_kind [NUM_SLOTS];
    logic [PROD_W-1:0] r1_prod;

    t_chan             r2_d [NUM_SLOTS];
    t_chan             r2_u [NUM_SLOTS];
    t_slot_op          r2_kind [NUM_SLOTS];
    t_chan             r2_a;
    t_wide             r2_t [NUM_SLOTS];

    t_chan             r3_d [NUM_SLOTS];
    t_chan             r3_u [NUM_SLOTS];
    t_slot_op          r3_kind [NUM_SLOTS];
    t_chan             r3_a;
    t_chan             r3_qt [NUM_SLOTS];

    t_chan             r4_d [NUM_SLOTS];
    t_slot_op          r4_kind [NUM_SLOTS];
    t_wide             r4_p1 [NUM_SLOTS];
    t_wide             r4_p2 [NUM_SLOTS];

    t_chan             r5_d [NUM_SLOTS];
    t_slot_op          r5_kind [NUM_SLOTS];
    t_wide             r5_n [NUM_SLOTS];

    t_chan             r6_d [NUM_SLOTS];
    t_slot_op          r6_kind [NUM_SLOTS];
    t_chan             r6_q [NUM_SLOTS];

    t_chan             r7_out [NUM_SLOTS];

    // Combinational values between stages.
    logic [PROD_W-GAIN_FRAC-1:0] gain_hi;
    t_chan                       n2_a;
    t_wide                       n4_p1 [NUM_SLOTS];
    t_wide                       n4_p2 [NUM_SLOTS];
    t_chan                       n7_out [NUM_SLOTS];
    logic [CH_BITS:0]            add_sum [NUM_SLOTS];

    always_comb begin
        gain_hi = r1_prod[PROD_W-1:GAIN_FRAC];
        n2_a = (gain_hi > (PROD_W-GAIN_FRAC)'(CH_MAX)) ? CH_MAX : gain_hi[CH_BITS-1:0];
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            case (r3_kind[i])
                OP_MIX: begin
                    n4_p1[i] = WIDE_W'(r3_d[i]) * WIDE_W'(CH_MAX - r3_a);
                    n4_p2[i] = WIDE_W'(r3_u[i]) * WIDE_W'(r3_a);
                end
                OP_MULT: begin
                    n4_p1[i] = WIDE_W'(r3_d[i]) * WIDE_W'(CH_MAX - r3_a);
                    n4_p2[i] = WIDE_W'(r3_qt[i]) * WIDE_W'(r3_a);
                end
                OP_ADD: begin
                    n4_p1[i] = '0;
                    n4_p2[i] = WIDE_W'(r3_u[i]) * WIDE_W'(r3_a);
                end
                OP_ALPHA: begin
                    n4_p1[i] = '0;
                    n4_p2[i] = WIDE_W'(CH_MAX - r3_d[i]) * WIDE_W'(r3_a);
                end
                default: begin
                    n4_p1[i] = '0;
                    n4_p2[i] = '0;
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            add_sum[i] = (CH_BITS+1)'(r6_d[i]) + (CH_BITS+1)'(r6_q[i]);
            case (r6_kind[i])
                OP_MIX, OP_MULT: n7_out[i] = r6_q[i];
                OP_ADD:   n7_out[i] = add_sum[i][CH_BITS] ? CH_MAX : add_sum[i][CH_BITS-1:0];
                // Alpha cannot overflow: the added part is at most max minus down.
                OP_ALPHA: n7_out[i] = add_sum[i][CH_BITS-1:0];
                default:  n7_out[i] = r6_d[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_d    <= in_d;
            r1_u    <= in_u;
            r1_kind <= in_kind;
            r1_prod <= n1_prod;
        end
        if (en2) begin
            r2_d    <= r1_d;
            r2_u    <= r1_u;
            r2_kind <= r1_kind;
            r2_a    <= n2_a;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r2_t[i] <= WIDE_W'(r1_d[i]) * WIDE_W'(r1_u[i]);
            end
        end
        if (en3) begin
            r3_d    <= r2_d;
            r3_u    <= r2_u;
            r3_kind <= r2_kind;
            r3_a    <= r2_a;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r3_qt[i] <= div_max(r2_t[i]);
            end
        end
        if (en4) begin
            r4_d    <= r3_d;
            r4_kind <= r3_kind;
            r4_p1   <= n4_p1;
            r4_p2   <= n4_p2;
        end
        if (en5) begin
            r5_d    <= r4_d;
            r5_kind <= r4_kind;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r5_n[i] <= r4_p1[i] + r4_p2[i];
            end
        end
        if (en6) begin
            r6_d    <= r5_d;
            r6_kind <= r5_kind;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r6_q[i] <= div_max(r5_n[i]);
            end
        end
        if (en7) begin
            r7_out <= n7_out;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            o_m_axis_tdata[i*CH_BITS +: CH_BITS] = r7_out[i];
        end
    end

    logic [NUM_SLOTS-1:0] alpha_mask1;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            alpha_mask1[i] = (r1_kind[i] == OP_ALPHA);
        end
    end

`ifndef SYNTHESIS
    // The input side only stalls when the output holds an item.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled while output register is empty");

    // At most one slot of a pixel carries alpha.
    a_one_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v |-> $onehot0(alpha_mask1))
        else $error("more than one alpha slot in a pixel");

    // An item behind a stalled full output register stays where it is.
    a_stage6_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r6_v && r7_v && !i_m_axis_tready) |=> (r6_v && $stable(r6_q[0])))
        else $error("stage six item changed during a stall");

    // Blending never lowers alpha.
    a_alpha_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r6_v && en7 && r6_kind[0] == OP_ALPHA) |=> (r7_out[0] >= $past(r6_d[0])))
        else $error("alpha result below lower alpha");
`endif

endmodule
